FILE: hdl/tglu_pkg.sv
package tglu_pkg;

  localparam int GLYPH_WIDTH   = 8;
  localparam int GLYPH_HEIGHT  = 8;
  localparam int ATLAS_COLUMNS = 16;

  localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [7:0] LAST_PRINTABLE  = 8'd127;
  localparam logic [7:0] NEWLINE_CODE    = 8'd10;
  localparam logic [7:0] FALLBACK_CODE   = 8'd63;
  localparam logic [7:0] FULL_LEVEL      = 8'd255;

  localparam int CFG_DATA_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_TINT_RED     = 3'd2,
    REG_TINT_GREEN   = 3'd3,
    REG_TINT_BLUE    = 3'd4,
    REG_TEXT_ALPHA   = 3'd5,
    REG_PALETTE_MODE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] col;
    logic signed [15:0] row;
  } cursor_t;

  typedef struct packed {
    logic tint_enable;
    logic blend_alpha;
    logic palette_select;
  } style_t;

  typedef struct packed {
    logic [14:0] dest_x;
    logic [14:0] dest_y;
    logic [6:0]  source_x;
    logic [5:0]  source_y;
    style_t      style;
  } cmd_t;

  // Clamp an 18-bit signed sum into the 16-bit signed cursor range
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/tglu_layout.sv
module tglu_layout (
  input  tglu_pkg::cursor_t   cursor,
  input  logic signed [15:0]  origin_x,
  input  logic signed [15:0]  origin_y,
  input  logic [7:0]          char_code,
  input  logic                string_start,
  input  tglu_pkg::style_t    style,
  output tglu_pkg::cursor_t   cursor_next,
  output logic                emit,
  output tglu_pkg::cmd_t      cmd
);
  import tglu_pkg::*;

  logic signed [15:0] col_base;
  logic signed [15:0] row_base;
  logic signed [17:0] col_sum;
  logic signed [17:0] row_bottom;
  logic signed [17:0] row_newline;
  logic [7:0]         glyph;
  logic [6:0]         glyph_index;
  logic               offscreen;

  assign col_base    = string_start ? origin_x : cursor.col;
  assign row_base    = string_start ? origin_y : cursor.row;
  assign col_sum     = 18'(col_base) + 18'(GLYPH_WIDTH);
  assign row_bottom  = 18'(row_base) + 18'(GLYPH_HEIGHT);
  assign row_newline = 18'(row_base) + 18'(GLYPH_HEIGHT + 1);
  assign offscreen   = (col_sum <= 18'sd0) || (row_bottom <= 18'sd0);

  assign glyph = (char_code < FIRST_PRINTABLE || char_code > LAST_PRINTABLE) ?
                 FALLBACK_CODE : char_code;
  assign glyph_index = 7'(glyph - FIRST_PRINTABLE);

  always_comb begin
    cmd.dest_x   = col_base[15] ? 15'd0 : col_base[14:0];
    cmd.dest_y   = row_base[15] ? 15'd0 : row_base[14:0];
    cmd.source_x = 7'((glyph_index % ATLAS_COLUMNS) * GLYPH_WIDTH);
    cmd.source_y = 6'((glyph_index / ATLAS_COLUMNS) * GLYPH_HEIGHT);
    cmd.style    = style;
    if (char_code == NEWLINE_CODE) begin
      cursor_next.col = origin_x;
      cursor_next.row = sat16(row_newline);
      emit            = 1'b0;
    end else begin
      cursor_next.col = sat16(col_sum);
      cursor_next.row = row_base;
      emit            = !offscreen;
    end
  end

endmodule

FILE: hdl/tglu_out_buf.sv
module tglu_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tglu_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output tglu_pkg::cmd_t out_cmd
);
  import tglu_pkg::*;

  logic skid_valid;
  cmd_t skid_cmd;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // Output slot frees up: drain the skid stage first
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_cmd    <= skid_cmd;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
        if (push) begin
          out_cmd <= push_cmd;
        end
      end
    end else if (push) begin
      // Hold the stalled transaction, park the new one
      skid_valid <= 1'b1;
      skid_cmd   <= push_cmd;
    end
  end

endmodule

FILE: hdl/text_glyph_command_layout_unit.sv
// Text glyph command layout unit.
// Input channel (char_valid / char_stall) carries one character byte and a
// string_start flag per transaction; one is taken every unstalled cycle.
// Output channel (cmd_valid / cmd_stall) carries one sprite command: clamped
// screen position, atlas position in the font grid and the style flags.
// Newlines and glyphs wholly off the top or left of the screen produce no
// command but still move the cursor.
// A command goes to the output register, or to the skid stage if one is stalled.
// Throughput: one character per unstalled cycle; the cursor add and saturate
// runs in the accepting cycle, so consecutive characters need no bubble.
// A two-entry output buffer (output register plus skid stage) keeps taking
// characters while one command waits; char_stall rises only when both
// entries hold commands and drops the cycle after the receiver takes one.
// Configuration: cfg_write with cfg_index selects origin_x, origin_y,
// tint_red, tint_green, tint_blue, text_alpha, palette_mode (index 0..6).
// Reset: cursor at (0,0), origin (0,0), tint and alpha at 255, palette 0,
// output buffer empty.
module text_glyph_command_layout_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [tglu_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tglu_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                   char_valid,
  output logic                                   char_stall,
  input  logic [7:0]                             char_code,
  input  logic                                   string_start,
  output logic                                   cmd_valid,
  input  logic                                   cmd_stall,
  output logic [14:0]                            dest_x,
  output logic [14:0]                            dest_y,
  output logic [6:0]                             source_x,
  output logic [5:0]                             source_y,
  output logic                                   tint_enable,
  output logic                                   blend_alpha,
  output logic                                   palette_select
);
  import tglu_pkg::*;

  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [7:0]         tint_red;
  logic [7:0]         tint_green;
  logic [7:0]         tint_blue;
  logic [7:0]         text_alpha;
  logic               palette_mode;

  cursor_t cursor;
  cursor_t cursor_next;
  style_t  style;
  cmd_t    new_cmd;
  cmd_t    out_cmd;
  logic    emit;
  logic    accept;
  logic    buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      tint_red     <= FULL_LEVEL;
      tint_green   <= FULL_LEVEL;
      tint_blue    <= FULL_LEVEL;
      text_alpha   <= FULL_LEVEL;
      palette_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:     origin_x     <= cfg_data;
        REG_ORIGIN_Y:     origin_y     <= cfg_data;
        REG_TINT_RED:     tint_red     <= cfg_data[7:0];
        REG_TINT_GREEN:   tint_green   <= cfg_data[7:0];
        REG_TINT_BLUE:    tint_blue    <= cfg_data[7:0];
        REG_TEXT_ALPHA:   text_alpha   <= cfg_data[7:0];
        REG_PALETTE_MODE: palette_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign style.tint_enable    = (tint_red != FULL_LEVEL) || (tint_green != FULL_LEVEL) ||
                                (tint_blue != FULL_LEVEL);
  assign style.blend_alpha    = (text_alpha != FULL_LEVEL);
  assign style.palette_select = palette_mode;

  assign char_stall = buf_full;
  assign accept     = char_valid && !buf_full;

  tglu_layout u_layout (
    .cursor       (cursor),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .char_code    (char_code),
    .string_start (string_start),
    .style        (style),
    .cursor_next  (cursor_next),
    .emit         (emit),
    .cmd          (new_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (accept) begin
      cursor <= cursor_next;
    end
  end

  tglu_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && emit),
    .push_cmd  (new_cmd),
    .full      (buf_full),
    .out_valid (cmd_valid),
    .out_stall (cmd_stall),
    .out_cmd   (out_cmd)
  );

  assign dest_x         = out_cmd.dest_x;
  assign dest_y         = out_cmd.dest_y;
  assign source_x       = out_cmd.source_x;
  assign source_y       = out_cmd.source_y;
  assign tint_enable    = out_cmd.style.tint_enable;
  assign blend_alpha    = out_cmd.style.blend_alpha;
  assign palette_select = out_cmd.style.palette_select;

endmodule

FILE: hdl/tglu_checker.sv
module tglu_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_stall,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input logic [14:0] dest_x,
  input logic [14:0] dest_y,
  input logic [6:0] source_x,
  input logic [5:0] source_y
);
  import tglu_pkg::*;

  // Buffer comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !cmd_valid && !char_stall)
    else $error("output buffer not empty after reset");

  // Input stalls only while a command is already waiting
  a_stall_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> cmd_valid)
    else $error("input stalled with no pending command");

  // One command taken frees the skid stage
  a_stall_releases: assert property (@(posedge clk) disable iff (rst)
    char_stall && !cmd_stall |=> !char_stall)
    else $error("input still stalled after command taken");

  // Stalled command holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_stall |=> cmd_valid && $stable(dest_x) && $stable(dest_y) &&
    $stable(source_x) && $stable(source_y))
    else $error("stalled command changed");

  // Atlas position lies on the glyph grid
  a_grid: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (int'(source_x) % GLYPH_WIDTH) == 0 &&
    (int'(source_y) % GLYPH_HEIGHT) == 0)
    else $error("atlas position off glyph grid");

endmodule

bind text_glyph_command_layout_unit tglu_checker u_tglu_checker (
  .clk        (clk),
  .rst        (rst),
  .char_stall (char_stall),
  .cmd_valid  (cmd_valid),
  .cmd_stall  (cmd_stall),
  .dest_x     (dest_x),
  .dest_y     (dest_y),
  .source_x   (source_x),
  .source_y   (source_y)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tglu_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int SETTLE       = 4;
  localparam int LONG_HOLD    = 64;
  localparam int MAX_REPORTED = 10;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [7:0]                 code;
    logic                       start;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [CFG_DATA_WIDTH-1:0]  data;
    cmd_t                       want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       char_valid = 1'b0;
  logic                       char_stall;
  logic [7:0]                 char_code = '0;
  logic                       string_start = 1'b0;
  logic                       cmd_valid;
  logic                       cmd_stall = 1'b0;
  logic [14:0]                dest_x;
  logic [14:0]                dest_y;
  logic [6:0]                 source_x;
  logic [5:0]                 source_y;
  logic                       tint_enable;
  logic                       blend_alpha;
  logic                       palette_select;

  // Layout state and register copies kept by the checker
  logic signed [15:0] cur_col, cur_row, org_x, org_y;
  logic [7:0]         tint_r, tint_g, tint_b, alpha_lvl;
  logic               pal_mode;

  cmd_t       pending_cmds[$];
  stim_row_t  directed[$];
  row_kind_t  drv_kind = ROW_PREDICT;
  cmd_t       drv_want = '0;
  bit         calm = 1'b0;
  bit         squeeze_req = 1'b0;
  int         errors = 0;

  text_glyph_command_layout_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .char_valid     (char_valid),
    .char_stall     (char_stall),
    .char_code      (char_code),
    .string_start   (string_start),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .dest_x         (dest_x),
    .dest_y         (dest_y),
    .source_x       (source_x),
    .source_y       (source_y),
    .tint_enable    (tint_enable),
    .blend_alpha    (blend_alpha),
    .palette_select (palette_select)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [15:0] clamp_cursor(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic cmd_t glyph_cmd(int dx, int dy, int sx, int sy, bit te, bit ba, bit ps);
    cmd_t c;
    c.dest_x = 15'(dx);
    c.dest_y = 15'(dy);
    c.source_x = 7'(sx);
    c.source_y = 6'(sy);
    c.style.tint_enable = te;
    c.style.blend_alpha = ba;
    c.style.palette_select = ps;
    return c;
  endfunction

  // Move the cursor for one character and build the sprite command it draws
  task automatic place_glyph(input logic [7:0] code, input logic start,
                             output bit emits, output cmd_t cmd);
    logic [7:0] glyph;
    int col, row, idx;
    emits = 1'b0;
    cmd = '0;
    if (start) begin
      cur_col = org_x;
      cur_row = org_y;
    end
    col = cur_col;
    row = cur_row;
    if (code == NEWLINE_CODE) begin
      cur_col = org_x;
      cur_row = clamp_cursor(row + GLYPH_HEIGHT + 1);
    end else begin
      glyph = (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) ? FALLBACK_CODE : code;
      // glyphs wholly off the left or top edge draw nothing
      if (col + GLYPH_WIDTH > 0 && row + GLYPH_HEIGHT > 0) begin
        idx = glyph - FIRST_PRINTABLE;
        emits = 1'b1;
        cmd = glyph_cmd(col < 0 ? 0 : col, row < 0 ? 0 : row,
                        (idx % ATLAS_COLUMNS) * GLYPH_WIDTH,
                        (idx / ATLAS_COLUMNS) * GLYPH_HEIGHT,
                        {tint_r, tint_g, tint_b} != {3{FULL_LEVEL}},
                        alpha_lvl < FULL_LEVEL, pal_mode);
      end
      cur_col = clamp_cursor(col + GLYPH_WIDTH);
    end
  endtask

  task automatic flag_error(string msg);
    errors++;
    if (errors <= MAX_REPORTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v)
      flag_error($sformatf("%s expected %0d got %0d", name, want_v, got_v));
  endtask

  // Checker: outputs first, then register writes, then accepted characters
  always @(posedge clk) begin
    cmd_t want, guess;
    bit emits;
    if (rst) begin
      cur_col = '0;
      cur_row = '0;
      org_x = '0;
      org_y = '0;
      tint_r = FULL_LEVEL;
      tint_g = FULL_LEVEL;
      tint_b = FULL_LEVEL;
      alpha_lvl = FULL_LEVEL;
      pal_mode = 1'b0;
      pending_cmds.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        if (pending_cmds.size() == 0) begin
          flag_error($sformatf("command with nothing expected, dest (%0d,%0d)",
                               dest_x, dest_y));
        end else begin
          want = pending_cmds.pop_front();
          check_field("dest_x", want.dest_x, dest_x);
          check_field("dest_y", want.dest_y, dest_y);
          check_field("source_x", want.source_x, source_x);
          check_field("source_y", want.source_y, source_y);
          check_field("tint_enable", want.style.tint_enable, tint_enable);
          check_field("blend_alpha", want.style.blend_alpha, blend_alpha);
          check_field("palette_select", want.style.palette_select, palette_select);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ORIGIN_X:     org_x = cfg_data;
          REG_ORIGIN_Y:     org_y = cfg_data;
          REG_TINT_RED:     tint_r = cfg_data[7:0];
          REG_TINT_GREEN:   tint_g = cfg_data[7:0];
          REG_TINT_BLUE:    tint_b = cfg_data[7:0];
          REG_TEXT_ALPHA:   alpha_lvl = cfg_data[7:0];
          REG_PALETTE_MODE: pal_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (char_valid && !char_stall) begin
        place_glyph(char_code, string_start, emits, guess);
        if (drv_kind == ROW_TYPED) pending_cmds.push_back(drv_want);
        else if (drv_kind == ROW_PREDICT && emits) pending_cmds.push_back(guess);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left, run_left;
    hold_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        cmd_stall = 1'b1;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        cmd_stall = 1'b1;
      end else if (run_left > 0) begin
        run_left--;
        cmd_stall = 1'b0;
      end else begin
        hold_left = pick_gap();
        run_left = $urandom_range(1, 12);
        cmd_stall = (hold_left > 0);
        if (hold_left > 0) hold_left--;
        else run_left--;
      end
    end
  end

  task automatic send_char(logic [7:0] code, logic start, row_kind_t kind, cmd_t want);
    @(negedge clk);
    char_valid = 1'b1;
    char_code = code;
    string_start = start;
    drv_kind = kind;
    drv_want = want;
    @(posedge clk);
    while (char_stall) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    if (n > 0) begin
      @(negedge clk);
      char_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    char_valid = 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    // a silent character may still be in flight
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic add_char(logic [7:0] code, logic start, row_kind_t kind, cmd_t want);
    stim_row_t r;
    r.kind = kind;
    r.code = code;
    r.start = start;
    r.idx = '0;
    r.data = '0;
    r.want = want;
    directed.push_back(r);
  endtask

  task automatic add_cfg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
    stim_row_t r;
    r.kind = ROW_CONFIG;
    r.code = '0;
    r.start = 1'b0;
    r.idx = idx;
    r.data = data;
    r.want = '0;
    directed.push_back(r);
  endtask

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 47) - 24);
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 600));
    endcase
  endfunction

  // Upper data bits are junk on purpose; only the low byte is stored
  function automatic logic [15:0] pick_level();
    logic [7:0] lvl;
    case ($urandom_range(0, 3))
      0, 1: lvl = FULL_LEVEL;
      2: lvl = 8'($urandom);
      default: lvl = $urandom_range(0, 1) ? 8'd0 : 8'd254;
    endcase
    return {8'($urandom), lvl};
  endfunction

  initial begin
    int n;
    int len;
    logic [7:0] code;
    bit in_cfg;

    // after reset: default origin, white tint, opaque, colour-keyed atlas
    add_char(8'h41, 1'b0, ROW_TYPED, glyph_cmd(0, 0, 8, 16, 0, 0, 0));
    add_char(8'h20, 1'b0, ROW_TYPED, glyph_cmd(8, 0, 0, 0, 0, 0, 0));
    add_char(8'h7F, 1'b0, ROW_TYPED, glyph_cmd(16, 0, 120, 40, 0, 0, 0));
    add_char(8'h00, 1'b0, ROW_TYPED, glyph_cmd(24, 0, 120, 8, 0, 0, 0));
    add_char(8'hFF, 1'b0, ROW_TYPED, glyph_cmd(32, 0, 120, 8, 0, 0, 0));
    add_char(8'h1F, 1'b0, ROW_TYPED, glyph_cmd(40, 0, 120, 8, 0, 0, 0));
    add_char(8'h80, 1'b0, ROW_TYPED, glyph_cmd(48, 0, 120, 8, 0, 0, 0));
    add_char(NEWLINE_CODE, 1'b0, ROW_SILENT, '0);
    add_char(8'h42, 1'b1, ROW_TYPED, glyph_cmd(0, 0, 16, 16, 0, 0, 0));
    add_char(8'h7E, 1'b0, ROW_PREDICT, '0);
    add_char(NEWLINE_CODE, 1'b1, ROW_SILENT, '0);
    add_char(8'h30, 1'b0, ROW_PREDICT, '0);
    // most negative origin: everything off-screen
    add_cfg(REG_ORIGIN_X, 16'h8000);
    add_cfg(REG_ORIGIN_Y, 16'h8000);
    add_char(8'h41, 1'b1, ROW_SILENT, '0);
    add_char(NEWLINE_CODE, 1'b0, ROW_SILENT, '0);
    add_cfg(REG_ORIGIN_Y, 16'h0000);
    add_char(8'h41, 1'b1, ROW_SILENT, '0);
    // partly visible glyph: destination clamps to zero
    add_cfg(REG_ORIGIN_X, 16'hFFF9);
    add_char(8'h41, 1'b1, ROW_TYPED, glyph_cmd(0, 0, 8, 16, 0, 0, 0));
    add_char(8'h41, 1'b0, ROW_TYPED, glyph_cmd(1, 0, 8, 16, 0, 0, 0));
    add_cfg(REG_ORIGIN_Y, 16'hFFF8);
    add_char(8'h41, 1'b1, ROW_SILENT, '0);
    // most positive origin: cursor saturates, all style flags set
    add_cfg(REG_ORIGIN_X, 16'h7FFF);
    add_cfg(REG_ORIGIN_Y, 16'h7FFF);
    add_cfg(REG_TINT_RED, 16'h00FE);
    add_cfg(REG_TEXT_ALPHA, 16'h00FE);
    add_cfg(REG_PALETTE_MODE, 16'h0001);
    add_char(8'h41, 1'b1, ROW_TYPED, glyph_cmd(32767, 32767, 8, 16, 1, 1, 1));
    add_char(8'h7A, 1'b0, ROW_PREDICT, '0);
    add_char(NEWLINE_CODE, 1'b0, ROW_SILENT, '0);
    add_char(8'h41, 1'b0, ROW_TYPED, glyph_cmd(32767, 32767, 8, 16, 1, 1, 1));
    add_cfg(REG_TINT_RED, 16'h00FF);
    add_cfg(REG_TINT_GREEN, 16'h0000);
    add_cfg(REG_TINT_BLUE, 16'h007F);
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_cfg(REG_TEXT_ALPHA, 16'h00FF);
    add_cfg(REG_PALETTE_MODE, 16'h0000);
    add_char(8'h61, 1'b1, ROW_PREDICT, '0);
    add_cfg(REG_TINT_GREEN, 16'h00FF);
    add_cfg(REG_TINT_BLUE, 16'h0000);
    add_char(8'h20, 1'b0, ROW_PREDICT, '0);
    add_char(NEWLINE_CODE, 1'b1, ROW_PREDICT, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    in_cfg = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CONFIG) begin
        if (!in_cfg) wait_drained();
        in_cfg = 1'b1;
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        in_cfg = 1'b0;
        send_char(directed[i].code, directed[i].start, directed[i].kind, directed[i].want);
        idle_input(pick_gap());
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_ORIGIN_X, pick_origin());
      write_reg(REG_ORIGIN_Y, pick_origin());
      write_reg(REG_TINT_RED, pick_level());
      write_reg(REG_TINT_GREEN, pick_level());
      write_reg(REG_TINT_BLUE, pick_level());
      write_reg(REG_TEXT_ALPHA, pick_level());
      write_reg(REG_PALETTE_MODE, 16'($urandom));
      // back-to-back phases; the first one also holds off the receiver
      calm = (p == 2 || p == 4);
      if (p == 2) squeeze_req = 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len && n < PHASE_ITEMS; i++) begin
          case ($urandom_range(0, 99)) inside
            [0:77]:  code = 8'($urandom_range(32, 127));
            [78:85]: code = NEWLINE_CODE;
            default: code = 8'($urandom);
          endcase
          send_char(code, i == 0 || $urandom_range(0, 49) == 0, ROW_PREDICT, '0);
          n++;
          idle_input(pick_gap());
          if (p == 5 && n == PHASE_ITEMS / 2) wait_drained();
        end
      end
    end
    calm = 1'b0;
    wait_drained();

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
